// File: sv/lfu_cache_table_unit_defines.svh
// Assertion macros used by the LFU cache table controller (lfu_ctl).
`ifndef LFU_CACHE_TABLE_UNIT_DEFINES_SVH
`define LFU_CACHE_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, checked at every rising clk edge outside reset.
`define LFU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising clk edge outside reset.
`define LFU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/lfu_pkg.sv
// Shared constants, types and structs of the LFU cache table.
package lfu_pkg;

  localparam int ENTRIES    = 16;
  localparam int KEY_BITS   = 16;
  localparam int VALUE_BITS = 32;
  localparam int COUNT_BITS = 16;
  localparam int CAP_BITS   = 5;

  localparam int IDX_BITS  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RANK_BITS = IDX_BITS;
  localparam int FILL_BITS = $clog2(ENTRIES + 1);
  localparam int CMP_BITS  = (FILL_BITS > CAP_BITS) ? FILL_BITS : CAP_BITS;

  localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(16);

  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_PUT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPD
  } lfu_state_t;

  typedef struct packed {
    logic                clr;
    logic                scan;
    logic                commit;
    logic [IDX_BITS-1:0] idx;
  } lfu_ctl_t;

  typedef struct packed {
    logic                  valid;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] data;
    logic [COUNT_BITS-1:0] count;
    logic [RANK_BITS-1:0]  rank;
  } lfu_entry_t;

  typedef struct packed {
    logic                  found;
    logic [IDX_BITS-1:0]   fidx;
    logic [COUNT_BITS-1:0] fcount;
    logic [RANK_BITS-1:0]  frank;
    logic [VALUE_BITS-1:0] fdata;
    logic                  evict;
    logic [IDX_BITS-1:0]   vidx;
    logic [RANK_BITS-1:0]  vrank;
    logic [KEY_BITS-1:0]   vkey;
    logic                  free_ok;
    logic [IDX_BITS-1:0]   free_idx;
  } lfu_scan_t;

endpackage

// File: sv/lfu_ctl.sv
// Request sequencer: accept, slot scan, commit.
`include "lfu_cache_table_unit_defines.svh"

module lfu_ctl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            out_busy,
  output lfu_pkg::lfu_ctl_t ctl
);
  import lfu_pkg::*;

  lfu_state_t          state_r, state_nxt;
  logic [IDX_BITS-1:0] idx_r, idx_nxt;
  logic                last;

  assign last = (idx_r == IDX_BITS'(ENTRIES - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      ST_IDLE: begin
        idx_nxt = '0;
        if (in_valid) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        idx_nxt = idx_r + 1'b1;
        if (last) begin
          state_nxt = ST_UPD;
          idx_nxt   = '0;
        end
      end
      ST_UPD: begin
        if (!out_busy) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    ctl.clr    = 1'b0;
    ctl.scan   = 1'b0;
    ctl.commit = 1'b0;
    ctl.idx    = idx_r;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        ctl.clr  = in_valid;
      end
      ST_SCAN: ctl.scan = 1'b1;
      ST_UPD:  ctl.commit = !out_busy;
      default: ;
    endcase
  end

  `LFU_ASSERT_NEXT(a_accept_scan, in_valid && in_ready, state_r == ST_SCAN && idx_r == '0, "accept did not start scan")
  `LFU_ASSERT_NEXT(a_scan_upd, state_r == ST_SCAN && last, state_r == ST_UPD, "scan did not end in update")
  `LFU_ASSERT_NOW(a_commit_free, ctl.commit, !out_busy && state_r == ST_UPD, "commit while output busy")

endmodule

// File: sv/lfu_scan.sv
// Shared compare unit: one slot per cycle for match, fill, free slot and victim.
module lfu_scan (
  input  logic                         clk,
  input  logic                         rst_n,
  input  lfu_pkg::lfu_ctl_t            ctl,
  input  logic [lfu_pkg::KEY_BITS-1:0] req_key,
  input  logic [lfu_pkg::CAP_BITS-1:0] cap,
  input  lfu_pkg::lfu_entry_t          ent,
  output lfu_pkg::lfu_scan_t           res
);
  import lfu_pkg::*;

  logic                  found_r, vok_r, free_ok_r;
  logic [IDX_BITS-1:0]   fidx_r, vidx_r, free_idx_r;
  logic [COUNT_BITS-1:0] fcount_r, vcount_r;
  logic [RANK_BITS-1:0]  frank_r, vrank_r;
  logic [VALUE_BITS-1:0] fdata_r;
  logic [KEY_BITS-1:0]   vkey_r;
  logic [FILL_BITS-1:0]  fill_r;
  logic                  match, better;
  logic [CMP_BITS-1:0]   cap_x, eff_cap, fill_x;

  assign match  = ent.valid && ent.key == req_key && !found_r;
  assign better = ent.valid && (!vok_r || ent.count < vcount_r ||
                  (ent.count == vcount_r && ent.rank > vrank_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r   <= 1'b0;
      vok_r     <= 1'b0;
      free_ok_r <= 1'b0;
      fill_r    <= '0;
    end else if (ctl.clr) begin
      found_r   <= 1'b0;
      vok_r     <= 1'b0;
      free_ok_r <= 1'b0;
      fill_r    <= '0;
    end else if (ctl.scan) begin
      if (ent.valid) fill_r <= fill_r + 1'b1;
      if (match) found_r <= 1'b1;
      if (better) vok_r <= 1'b1;
      if (!ent.valid) free_ok_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.scan) begin
      if (match) begin
        fidx_r   <= ctl.idx;
        fcount_r <= ent.count;
        frank_r  <= ent.rank;
        fdata_r  <= ent.data;
      end
      if (better) begin
        vidx_r   <= ctl.idx;
        vcount_r <= ent.count;
        vrank_r  <= ent.rank;
        vkey_r   <= ent.key;
      end
      if (!ent.valid && !free_ok_r) free_idx_r <= ctl.idx;
    end
  end

  always_comb begin
    cap_x  = CMP_BITS'(cap);
    fill_x = CMP_BITS'(fill_r);
    if (cap_x == '0) eff_cap = CMP_BITS'(1);
    else if (cap_x > CMP_BITS'(ENTRIES)) eff_cap = CMP_BITS'(ENTRIES);
    else eff_cap = cap_x;
  end

  assign res.found    = found_r;
  assign res.fidx     = fidx_r;
  assign res.fcount   = fcount_r;
  assign res.frank    = frank_r;
  assign res.fdata    = fdata_r;
  assign res.evict    = !found_r && vok_r && fill_x >= eff_cap;
  assign res.vidx     = vidx_r;
  assign res.vrank    = vrank_r;
  assign res.vkey     = vkey_r;
  assign res.free_ok  = free_ok_r;
  assign res.free_idx = free_idx_r;

endmodule

// File: sv/lfu_store.sv
// Slot storage with per-slot recency rank update on commit.
module lfu_store (
  input  logic                           clk,
  input  logic                           rst_n,
  input  lfu_pkg::lfu_ctl_t              ctl,
  input  logic                           req_action,
  input  logic [lfu_pkg::KEY_BITS-1:0]   req_key,
  input  logic [lfu_pkg::VALUE_BITS-1:0] req_value,
  input  lfu_pkg::lfu_scan_t             res,
  output lfu_pkg::lfu_entry_t            ent
);
  import lfu_pkg::*;

  logic [ENTRIES-1:0]    valid_r, valid_nxt;
  logic [KEY_BITS-1:0]   key_r   [ENTRIES];
  logic [VALUE_BITS-1:0] data_r  [ENTRIES];
  logic [COUNT_BITS-1:0] count_r [ENTRIES];
  logic [RANK_BITS-1:0]  rank_r  [ENTRIES];
  logic [RANK_BITS-1:0]  rank_nxt[ENTRIES];
  logic [IDX_BITS-1:0]   ins_idx, wa;
  logic                  do_ins, we_data, we_cnt;
  logic [COUNT_BITS-1:0] cnt_w;

  assign ent.valid = valid_r[ctl.idx];
  assign ent.key   = key_r[ctl.idx];
  assign ent.data  = data_r[ctl.idx];
  assign ent.count = count_r[ctl.idx];
  assign ent.rank  = rank_r[ctl.idx];

  always_comb begin
    ins_idx = (res.evict && !(res.free_ok && res.free_idx < res.vidx)) ? res.vidx
                                                                       : res.free_idx;
    do_ins  = !res.found && req_action == ACT_PUT && (res.evict || res.free_ok);
    wa      = res.found ? res.fidx : ins_idx;
    we_cnt  = ctl.commit && (res.found || do_ins);
    we_data = ctl.commit && (res.found ? req_action == ACT_PUT : do_ins);
    if (!res.found) cnt_w = COUNT_BITS'(1);
    else if (res.fcount == '1) cnt_w = res.fcount;
    else cnt_w = res.fcount + 1'b1;
    for (int i = 0; i < ENTRIES; i++) begin
      valid_nxt[i] = valid_r[i];
      rank_nxt[i]  = rank_r[i];
      if (res.found) begin
        if (valid_r[i] && IDX_BITS'(i) != res.fidx && rank_r[i] < res.frank)
          rank_nxt[i] = rank_r[i] + 1'b1;
        if (IDX_BITS'(i) == res.fidx) rank_nxt[i] = '0;
      end else if (do_ins) begin
        if (res.evict && IDX_BITS'(i) == res.vidx) valid_nxt[i] = 1'b0;
        if (valid_nxt[i])
          rank_nxt[i] = rank_r[i] - RANK_BITS'(res.evict && rank_r[i] > res.vrank) + 1'b1;
        if (IDX_BITS'(i) == ins_idx) begin
          valid_nxt[i] = 1'b1;
          rank_nxt[i]  = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= '0;
    else if (ctl.commit) valid_r <= valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      for (int i = 0; i < ENTRIES; i++) rank_r[i] <= rank_nxt[i];
    end
    if (we_cnt) count_r[wa] <= cnt_w;
    if (we_data) data_r[wa] <= req_value;
    if (ctl.commit && do_ins) key_r[wa] <= req_key;
  end

endmodule

// File: sv/lfu_cache_table_unit.sv
// Top level of the LFU cache table: ports, request and result registers.
//
// Key/value cache of 16 slots with least-frequently-used replacement, ties
// broken toward the least recently touched entry. Each get or put beat gives
// one result beat. A request is accepted, scanned one slot per cycle through a
// single key and count compare unit, then committed; in_ready is low meanwhile.
// The result beat is registered in the output register at the commit. The next
// request is taken while the previous result still waits on out_ready, but the
// commit waits for the output register to free up. The user must see that
// capacity is written only while the block is idle; the block itself does not
// enforce it. 0 acts as 1, values above 16 act as 16.
module lfu_cache_table_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_action,
  input  logic [lfu_pkg::KEY_BITS-1:0]   in_key,
  input  logic [lfu_pkg::VALUE_BITS-1:0] in_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_hit,
  output logic [lfu_pkg::VALUE_BITS-1:0] out_read_value,
  output logic                           out_evicted,
  output logic [lfu_pkg::KEY_BITS-1:0]   out_evicted_key,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lfu_pkg::CAP_BITS-1:0]   cfg_data
);
  import lfu_pkg::*;

  lfu_ctl_t              ctl;
  lfu_scan_t             res;
  lfu_entry_t            ent;
  logic [CAP_BITS-1:0]   cap_r;
  logic                  act_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] value_r;
  logic                  out_valid_r;
  logic                  hit_r, evicted_r;
  logic [VALUE_BITS-1:0] read_value_r;
  logic [KEY_BITS-1:0]   evicted_key_r;
  logic                  ev_now;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) cap_r <= CAP_RESET;
    else if (cfg_valid) cap_r <= cfg_data;
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      act_r   <= in_action;
      key_r   <= in_key;
      value_r <= in_value;
    end
  end

  lfu_ctl u_ctl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_busy (out_valid_r && !out_ready),
    .ctl      (ctl)
  );

  lfu_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .req_key (key_r),
    .cap     (cap_r),
    .ent     (ent),
    .res     (res)
  );

  lfu_store u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .req_action (act_r),
    .req_key    (key_r),
    .req_value  (value_r),
    .res        (res),
    .ent        (ent)
  );

  assign ev_now = !res.found && act_r == ACT_PUT && res.evict;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (ctl.commit) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      hit_r         <= res.found;
      read_value_r  <= (res.found && act_r == ACT_GET) ? res.fdata : '0;
      evicted_r     <= ev_now;
      evicted_key_r <= ev_now ? res.vkey : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = hit_r;
  assign out_read_value  = read_value_r;
  assign out_evicted     = evicted_r;
  assign out_evicted_key = evicted_key_r;

endmodule
